// ===== sv/per_process_address_range_cache_top_macros.svh =====
// Assertion macros for the range cache.
`ifndef PER_PROCESS_ADDRESS_RANGE_CACHE_TOP_MACROS_SVH
`define PER_PROCESS_ADDRESS_RANGE_CACHE_TOP_MACROS_SVH
// Implication checked on every clock, off during reset.
`define PPARC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PPARC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/pparc_pkg.sv =====
// Package: constants and types for the range cache.
package pparc_pkg;
  localparam int PROCESS_SLOTS_DEF = 24;
  localparam int RANGES_PER_SLOT_DEF = 192;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HIT = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] process_slot;
    logic [7:0] range_slot;
    logic [63:0] offset;
  } result_t;
endpackage

// ===== sv/pparc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module pparc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/per_process_address_range_cache_top.sv =====
// Top level: per-process address range cache with sequencer and range memory.
//   channel | dir | signals
//   in      | in  | in_valid/in_ready, opcode, process_id, address, range_size
//   out     | out | out_valid/out_ready, status, process_slot, range_slot, offset
// One item at a time: no new beat is taken until the last result leaves S_DONE.
// The slot scan walks the process slots in order; the range scan then reads the
// ranges below the found slot's count, and an insert ends in a write state.
// Reset is immediate: slot ids and counts live in flip-flops; range memory
// is read only below a slot's count. A stalled result holds in the output
// register while the next beat is taken; a second result waits in S_DONE.
module per_process_address_range_cache_top
  import pparc_pkg::*;
#(
  parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF,
  parameter int RANGES_PER_SLOT = RANGES_PER_SLOT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] process_id,
  input  logic [63:0] address,
  input  logic [63:0] range_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  process_slot,
  output logic [7:0]  range_slot,
  output logic [63:0] offset
);
`include "per_process_address_range_cache_top_macros.svh"
  localparam int SW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int RW = (RANGES_PER_SLOT > 1) ? $clog2(RANGES_PER_SLOT) : 1;
  localparam int CW = $clog2(RANGES_PER_SLOT + 1);
  localparam int DEPTH = PROCESS_SLOTS * RANGES_PER_SLOT;
  localparam int AW = $clog2(DEPTH + 1);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SLOT = 3'd1;
  localparam logic [2:0] S_RANGE = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  // 2^(16k) mod RANGES_PER_SLOT for folding the base into 28 bits
  localparam logic [10:0] FOLD0 = 11'(64'd1 % 64'(RANGES_PER_SLOT));
  localparam logic [10:0] FOLD1 = 11'((64'd1 << 16) % 64'(RANGES_PER_SLOT));
  localparam logic [10:0] FOLD2 = 11'((64'd1 << 32) % 64'(RANGES_PER_SLOT));
  localparam logic [10:0] FOLD3 = 11'((64'd1 << 48) % 64'(RANGES_PER_SLOT));
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(RANGES_PER_SLOT));

  logic [2:0] state;
  logic [31:0] slot_process [PROCESS_SLOTS];
  logic [CW-1:0] slot_count [PROCESS_SLOTS];
  logic [SW-1:0] replace_pointer;
  logic [1:0] op;
  logic [31:0] pid;
  logic [63:0] addr, size;
  logic [SW-1:0] si;
  logic [CW-1:0] ri;
  logic rd_pending;
  logic [CW-1:0] rd_idx;
  logic [SW-1:0] fslot;
  logic [CW-1:0] cnt;
  logic [RW-1:0] entry;
  result_t res;
  logic res_ready;
  logic [127:0] rdata;
  logic [AW-1:0] ra_full, wa_full;
  logic we;
  logic [63:0] end_addr;
  logic [RW-1:0] mod_entry;
  logic [27:0] fold;
  logic [27:0] quot;
  logic [11:0] rem;

  assign in_ready = (state == S_IDLE);
  assign res_ready = !out_valid || out_ready;

  // slot index times RANGES_PER_SLOT plus entry, one small multiply
  assign ra_full = AW'(fslot) * AW'(RANGES_PER_SLOT) + AW'(ri);
  assign wa_full = AW'(fslot) * AW'(RANGES_PER_SLOT) + AW'(entry);
  assign we = (state == S_WRITE);

  // base mod RANGES_PER_SLOT: fold, reciprocal estimate, one correction;
  // settles through the fold, quot and rem registers, well before a full slot is scanned
  always_ff @(posedge clk) begin
    fold <= 28'(addr[15:0]) * 28'(FOLD0) + 28'(addr[31:16]) * 28'(FOLD1)
          + 28'(addr[47:32]) * 28'(FOLD2) + 28'(addr[63:48]) * 28'(FOLD3);
    quot <= 28'((61'(fold) * 61'(RECIP)) >> 32);
    rem <= 12'(fold - 28'(quot * 28'(RANGES_PER_SLOT)));
  end
  assign mod_entry = RW'((rem >= 12'(RANGES_PER_SLOT)) ? rem - 12'(RANGES_PER_SLOT) : rem);

  pparc_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(wa_full[$clog2(DEPTH)-1:0]),
    .wdata({addr, size}), .raddr(ra_full[$clog2(DEPTH)-1:0]), .rdata(rdata)
  );

  assign end_addr = rdata[127:64] + rdata[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      replace_pointer <= SW'(PROCESS_SLOTS - 1);
      rd_pending <= 1'b0;
      for (int k = 0; k < PROCESS_SLOTS; k++) begin
        slot_process[k] <= '0;
        slot_count[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode; pid <= process_id; addr <= address; size <= range_size;
            si <= '0; ri <= '0; rd_pending <= 1'b0;
            res.process_slot <= '0;
            res.range_slot <= '0;
            res.offset <= '0;
            if (opcode == OP_CLEAR) begin
              for (int k = 0; k < PROCESS_SLOTS; k++) begin
                slot_process[k] <= '0;
                slot_count[k] <= '0;
              end
              replace_pointer <= SW'(PROCESS_SLOTS - 1);
              res.status <= ST_OK;
              state <= S_DONE;
            end else if (opcode == OP_INSERT && (process_id == '0 || address == '0
                         || range_size == '0)) begin
              res.status <= ST_REJECT;
              state <= S_DONE;
            end else if (opcode == OP_INSERT || opcode == OP_LOOKUP) begin
              if (process_id == '0) begin
                res.status <= ST_MISS;
                state <= S_DONE;
              end else begin
                state <= S_SLOT;
              end
            end else begin
              res.status <= ST_REJECT;
              state <= S_DONE;
            end
          end
        end
        S_SLOT: begin
          if (slot_process[si] == pid) begin
            fslot <= si; cnt <= slot_count[si]; ri <= '0; rd_pending <= 1'b0;
            state <= S_RANGE;
          end else if (32'(si) == 32'(PROCESS_SLOTS - 1)) begin
            if (op == OP_LOOKUP) begin
              res.status <= ST_MISS;
              state <= S_DONE;
            end else begin
              fslot <= (32'(replace_pointer) == 32'(PROCESS_SLOTS - 1)) ? '0
                       : replace_pointer + SW'(1);
              replace_pointer <= (32'(replace_pointer) == 32'(PROCESS_SLOTS - 1)) ? '0
                                 : replace_pointer + SW'(1);
              cnt <= '0; ri <= '0; rd_pending <= 1'b0;
              state <= S_RANGE;
            end
          end else begin
            si <= si + SW'(1);
          end
        end
        S_RANGE: begin
          // issue read of ri; check previous read
          if (rd_pending && (op == OP_INSERT ? rdata[127:64] == addr
              : (rdata[63:0] != '0 && end_addr >= rdata[127:64]
                 && addr >= rdata[127:64] && addr < end_addr))) begin
            if (op == OP_INSERT) begin
              entry <= RW'(rd_idx);
              state <= S_WRITE;
            end else begin
              res.status <= ST_HIT;
              res.process_slot <= 5'(fslot);
              res.range_slot <= 8'(rd_idx);
              res.offset <= addr - rdata[127:64];
              state <= S_DONE;
            end
          end else if (ri >= cnt) begin
            if (rd_pending) begin
              rd_pending <= 1'b0;
            end else if (op == OP_LOOKUP) begin
              // continue slot scan after this slot
              if (32'(fslot) == 32'(PROCESS_SLOTS - 1)) begin
                res.status <= ST_MISS;
                state <= S_DONE;
              end else begin
                si <= fslot + SW'(1);
                state <= S_SLOT;
              end
            end else begin
              if (32'(cnt) < 32'(RANGES_PER_SLOT)) begin
                entry <= RW'(cnt);
                slot_count[fslot] <= cnt + CW'(1);
              end else begin
                entry <= mod_entry;
              end
              slot_process[fslot] <= pid;
              state <= S_WRITE;
            end
          end else begin
            rd_pending <= 1'b1;
            rd_idx <= ri;
            ri <= ri + CW'(1);
          end
        end
        S_WRITE: begin
          res.status <= ST_OK;
          res.process_slot <= 5'(fslot);
          res.range_slot <= 8'(entry);
          res.offset <= '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && res_ready) begin
      out_valid <= 1'b1;
      status <= res.status;
      process_slot <= res.process_slot;
      range_slot <= res.range_slot;
      offset <= res.offset;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `PPARC_ASSERT_IMP(a_ready_idle, in_ready, state == S_IDLE)
  `PPARC_ASSERT_IMP(a_hit_offset, out_valid && status != ST_HIT, offset == '0)
  `PPARC_ASSERT_NEXT(a_done_out, state == S_DONE && res_ready, out_valid)
endmodule
